@@ rtl/hme_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hme_pkg: shared types and constants
// Widths, reset values, controller states and the command/status structs
// used between the controller and the datapath.
// ----------------------------------------------------------------------------
package hme_pkg;

  localparam int BYTE_W          = 8;
  localparam int PARITY_W        = 4;
  localparam int MIN_PARITY      = 3;
  localparam int MAX_PARITY_DEF  = 8;
  localparam int STORE_BYTES_DEF = 32;
  localparam logic [PARITY_W-1:0] PARITY_RESET = 4'd5;

  localparam logic MODE_EXTRACT = 1'b0;
  localparam logic MODE_EMBED   = 1'b1;

  typedef enum logic [1:0] {
    ST_IN,
    ST_READ,
    ST_SEND
  } hme_state_t;

  // Controller to datapath.
  typedef struct packed {
    logic take;     // input item accepted this cycle
    logic read;     // fetch the codeword byte at the readout index
    logic advance;  // result item accepted, move to the next byte
  } hme_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic in_last;   // the byte at the input closes the codeword
    logic in_embed;  // mode of the item at the input
    logic out_last;  // the result item on the output is the final one
  } hme_stat_t;

endpackage
`default_nettype wire

@@ rtl/hme_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hme_if: channel interfaces
// Valid/ready channels for cover bytes, result items and the configuration
// register write.
// ----------------------------------------------------------------------------
interface hme_cover_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [7:0] cover_byte;
  logic [7:0] message;

  modport source (output valid, mode, cover_byte, message, input ready);
  modport sink   (input valid, mode, cover_byte, message, output ready);
endinterface

interface hme_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [7:0] syndrome;
  logic       last;

  modport source (output valid, out_byte, syndrome, last, input ready);
  modport sink   (input valid, out_byte, syndrome, last, output ready);
endinterface

interface hme_cfg_if;
  logic       valid;
  logic       ready;
  logic [3:0] parity_bits;

  modport source (output valid, parity_bits, input ready);
  modport sink   (input valid, parity_bits, output ready);
endinterface
`default_nettype wire

@@ rtl/hme_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hme_ctrl: sequencing controller
// Takes cover bytes, then walks the codeword store once per result item
// in embed mode, or presents the single syndrome item in extract mode.
// ----------------------------------------------------------------------------
module hme_ctrl
  import hme_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  hme_stat_t stat,
  output hme_cmd_t  cmd
);

  hme_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IN;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    in_ready    = 1'b0;
    out_valid   = 1'b0;
    cmd         = '0;
    case (state)
      ST_IN: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.take = 1'b1;
          if (stat.in_last) begin
            state_next = stat.in_embed ? ST_READ : ST_SEND;
          end
        end
      end
      ST_READ: begin
        cmd.read   = 1'b1;
        state_next = ST_SEND;
      end
      ST_SEND: begin
        out_valid = 1'b1;
        if (out_ready) begin
          cmd.advance = 1'b1;
          state_next  = stat.out_last ? ST_IN : ST_READ;
        end
      end
      default: begin
        state_next = ST_IN;
      end
    endcase
  end

endmodule
`default_nettype wire

@@ rtl/hme_dp.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hme_dp: syndrome and codeword datapath
// Running syndrome, byte store, flip position and readout of the
// modified codeword.
// ----------------------------------------------------------------------------
module hme_dp
  import hme_pkg::*;
#(
  parameter int MAX_PARITY  = MAX_PARITY_DEF,
  parameter int STORE_BYTES = STORE_BYTES_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  hme_cmd_t            cmd,
  output hme_stat_t           stat,
  input  logic                cfg_we,
  input  logic [PARITY_W-1:0] cfg_parity,
  input  logic                mode,
  input  logic [BYTE_W-1:0]   cover_byte,
  input  logic [BYTE_W-1:0]   message,
  output logic [BYTE_W-1:0]   out_byte,
  output logic [BYTE_W-1:0]   syndrome,
  output logic                last,
  output logic                embed
);

  localparam int IDX_W = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;

  logic [PARITY_W-1:0] parity_bits;
  logic [BYTE_W-1:0]   run_syn;
  logic [IDX_W-1:0]    byte_index;
  logic [BYTE_W-1:0]   mem [STORE_BYTES];

  logic [BYTE_W-1:0]   syn_out;
  logic                embed_r;
  logic                flip_en;
  logic [4:0]          flip_idx;
  logic [BYTE_W-1:0]   flip_mask;
  logic [IDX_W-1:0]    rd_idx;
  logic [BYTE_W-1:0]   rd_data;

  logic [PARITY_W-1:0] k_eff;
  logic [BYTE_W-1:0]   tot;
  logic [5:0]          nbytes_raw;
  logic [5:0]          nbytes;
  logic [IDX_W-1:0]    nb_m1;
  logic [IDX_W-1:0]    b;
  logic [BYTE_W-1:0]   syn_new;
  logic [8:0]          pos;
  logic [BYTE_W-1:0]   h;
  logic [BYTE_W-1:0]   hm1;

  // Effective code size; the register value is clamped to the legal range.
  always_comb begin
    if (parity_bits < PARITY_W'(MIN_PARITY)) begin
      k_eff = PARITY_W'(MIN_PARITY);
    end else if (parity_bits > PARITY_W'(MAX_PARITY)) begin
      k_eff = PARITY_W'(MAX_PARITY);
    end else begin
      k_eff = parity_bits;
    end
    tot        = BYTE_W'((9'd1 << k_eff) - 9'd1);
    nbytes_raw = 6'd1 << (k_eff - PARITY_W'(MIN_PARITY));
    nbytes     = (nbytes_raw > 6'(STORE_BYTES)) ? 6'(STORE_BYTES) : nbytes_raw;
    nb_m1      = IDX_W'(nbytes - 6'd1);
    b          = (byte_index > nb_m1) ? nb_m1 : byte_index;
  end

  // Syndrome update over the eight bits of the incoming byte, MSB first.
  always_comb begin
    syn_new = run_syn;
    pos     = '0;
    for (int j = 0; j < 8; j++) begin
      pos = 9'({b, 3'(j)}) + 9'd1;
      if (pos <= {1'b0, tot} && cover_byte[7-j]) begin
        syn_new = syn_new ^ pos[BYTE_W-1:0];
      end
    end
    h   = syn_new ^ (message & tot);
    hm1 = h - 8'd1;
  end

  assign stat.in_last  = (b == nb_m1);
  assign stat.in_embed = (mode == MODE_EMBED);
  assign stat.out_last = !embed_r || (rd_idx == nb_m1);

  always_ff @(posedge clk) begin
    if (rst) begin
      parity_bits <= PARITY_RESET;
      run_syn     <= '0;
      byte_index  <= '0;
      embed_r     <= 1'b0;
      flip_en     <= 1'b0;
      rd_idx      <= '0;
    end else if (cfg_we) begin
      // A register write abandons any partial codeword.
      parity_bits <= cfg_parity;
      run_syn     <= '0;
      byte_index  <= '0;
    end else if (cmd.take) begin
      if (stat.in_last) begin
        run_syn    <= '0;
        byte_index <= '0;
        embed_r    <= stat.in_embed;
        flip_en    <= (h != '0) && ({1'b0, hm1[7:3]} < nbytes);
        rd_idx     <= '0;
      end else begin
        run_syn    <= syn_new;
        byte_index <= b + IDX_W'(1);
      end
    end else if (cmd.advance) begin
      rd_idx <= rd_idx + IDX_W'(1);
    end
  end

  // Payload registers, no reset needed.
  always_ff @(posedge clk) begin
    if (cmd.take && stat.in_last) begin
      syn_out   <= syn_new;
      flip_idx  <= hm1[7:3];
      flip_mask <= 8'h80 >> hm1[2:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      mem[b] <= cover_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.read) begin
      rd_data <= mem[rd_idx];
    end
  end

  // The flip is applied on the way out instead of rewriting the store.
  always_comb begin
    if (!embed_r) begin
      out_byte = '0;
    end else if (flip_en && (5'(rd_idx) == flip_idx)) begin
      out_byte = rd_data ^ flip_mask;
    end else begin
      out_byte = rd_data;
    end
  end

  assign syndrome = syn_out;
  assign last     = stat.out_last;
  assign embed    = embed_r;

endmodule
`default_nettype wire

@@ rtl/hamming_matrix_embedding.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hamming_matrix_embedding: Hamming code matrix embedding
// Syndrome coding over a byte stream of cover codewords.
// ----------------------------------------------------------------------------
// Usage:
//   cover_stream : one cover byte per item, MSB first; mode and message are
//            taken with the last byte of a codeword (ceil((2^k-1)/8) bytes).
//   result : extract mode gives one item holding the syndrome; embed mode
//            gives one item per codeword byte, flip applied, last on the end.
//   cfg    : writes parity_bits (k); always ready, and it drops any partly
//            received codeword. Write it only while the block is idle.
// Timing: cover bytes are taken back to back while the block waits for input.
// The extract result is valid the cycle after the last byte. In embed mode
// each result byte is a store read, then the output, and the bytes of a
// codeword are read out in order. Cover items are not taken while results
// are pending; the controller serves input and readout in turn.
// Reset: k returns to 5 and the partial codeword is dropped.
// Stall: a result item holds on the port until ready is seen.
// ----------------------------------------------------------------------------
module hamming_matrix_embedding
  import hme_pkg::*;
#(
  parameter int MAX_PARITY  = MAX_PARITY_DEF,
  parameter int STORE_BYTES = STORE_BYTES_DEF
) (
  input  logic         clk,
  input  logic         rst,
  hme_cover_if.sink    cover_stream,
  hme_result_if.source result,
  hme_cfg_if.sink      cfg
);

  hme_cmd_t  cmd;
  hme_stat_t stat;
  logic      embed;

  assign cfg.ready = 1'b1;

  hme_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (cover_stream.valid),
    .in_ready  (cover_stream.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  hme_dp #(
    .MAX_PARITY  (MAX_PARITY),
    .STORE_BYTES (STORE_BYTES)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .cfg_we     (cfg.valid),
    .cfg_parity (cfg.parity_bits),
    .mode       (cover_stream.mode),
    .cover_byte (cover_stream.cover_byte),
    .message    (cover_stream.message),
    .out_byte   (result.out_byte),
    .syndrome   (result.syndrome),
    .last       (result.last),
    .embed      (embed)
  );

  // Input and output never run at the same time.
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(cover_stream.ready && result.valid))
    else $error("cover and result channels active together");

  // After the final item of a codeword the block is back to taking bytes.
  a_back_to_input: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.ready && result.last |=> cover_stream.ready)
    else $error("not ready for cover bytes after final result");

  // Extract results carry a zero byte and are always the final item.
  a_extract_item: assert property (@(posedge clk) disable iff (rst)
    result.valid && !embed |-> result.out_byte == '0 && result.last)
    else $error("malformed extract result");

endmodule
`default_nettype wire

@@ tb/tb_hamming_matrix_embedding.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_hamming_matrix_embedding: self-checking bench for the matrix embedder
// Cover bytes are fed from a queue through a valid/ready driver with random
// idle bursts, results are taken by a monitor with random stalls, and every
// result item is checked against an in-bench model of the syndrome coder. The
// run walks the parity setting across its legal range and beyond, including
// codewords abandoned halfway by a register write.
// ----------------------------------------------------------------------------
module tb_hamming_matrix_embedding;
  import hme_pkg::*;

  localparam int CYCLE_LIMIT   = 300000;
  localparam int SETTLE_CYCLES = 12;
  localparam int REPORT_LIMIT  = 10;

  typedef struct {
    logic       mode;
    logic [7:0] cover_byte;
    logic [7:0] message;
    bit         wait_drain;  // hold this item until all results are in
  } cover_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [7:0] syndrome;
    logic       last;
  } result_t;

  logic clk = 1'b0;
  logic rst;

  hme_cover_if  cover_ch ();
  hme_result_if result_ch ();
  hme_cfg_if    cfg_ch ();

  hamming_matrix_embedding dut (
    .clk          (clk),
    .rst          (rst),
    .cover_stream (cover_ch),
    .result       (result_ch),
    .cfg          (cfg_ch)
  );

  always #1 clk = ~clk;

  cover_item_t cover_queue[$];
  result_t     due_results[$];
  cover_item_t next_item;

  // Model state of the embedder.
  logic [3:0] parity_reg = PARITY_RESET;
  logic [7:0] syn_acc = 8'h00;
  int         byte_pos = 0;
  logic [7:0] codeword_copy [STORE_BYTES_DEF];

  int items_queued = 0;
  int items_taken = 0;
  int errors = 0;
  int cycle_count = 0;
  int send_gap = 0;
  int stall_left = 0;
  bit calm = 1'b0;
  bit bursts_on = 1'b1;

  function automatic int eff_parity(input logic [3:0] value);
    int k;
    k = value;
    if (k < MIN_PARITY) k = MIN_PARITY;
    if (k > MAX_PARITY_DEF) k = MAX_PARITY_DEF;
    return k;
  endfunction

  function automatic int codeword_len(input logic [3:0] value);
    int n;
    n = (((1 << eff_parity(value)) - 1) - 1) / 8 + 1;
    if (n > STORE_BYTES_DEF) n = STORE_BYTES_DEF;
    return n;
  endfunction

  // Folds one accepted cover byte into the running syndrome and, on the
  // codeword's last byte, queues the result items the block must produce.
  task automatic absorb_cover_byte(input logic mode, input logic [7:0] cb,
                                   input logic [7:0] msg);
    int k, tot, nb, b, pos, hv;
    logic [7:0] syn, h;
    result_t r;
    k = eff_parity(parity_reg);
    tot = (1 << k) - 1;
    nb = codeword_len(parity_reg);
    b = byte_pos;
    if (b >= nb) b = nb - 1;
    codeword_copy[b] = cb;
    syn = syn_acc;
    for (int j = 0; j < 8; j++) begin
      pos = b * 8 + j + 1;
      if (pos <= tot && cb[7-j]) syn = syn ^ 8'(pos);
    end
    if (b + 1 < nb) begin
      syn_acc = syn;
      byte_pos = b + 1;
      return;
    end
    syn_acc = 8'h00;
    byte_pos = 0;
    if (mode == MODE_EXTRACT) begin
      r.out_byte = 8'h00;
      r.syndrome = syn;
      r.last = 1'b1;
      due_results.push_back(r);
      return;
    end
    h = syn ^ (msg & 8'((1 << k) - 1));
    if (h != 8'h00) begin
      hv = h;
      if ((hv - 1) / 8 < nb)
        codeword_copy[(hv - 1) / 8] ^= 8'h80 >> ((hv - 1) % 8);
    end
    for (int i = 0; i < nb; i++) begin
      r.out_byte = codeword_copy[i];
      r.syndrome = syn;
      r.last = (i + 1 == nb);
      due_results.push_back(r);
    end
  endtask

  // Queues count cover bytes at the current setting; a negative fill gives
  // random bytes. Mode and message are random except on the closing byte.
  task automatic queue_codeword(input logic mode, input logic [7:0] msg, input int fill,
                                input int count, input bit drain);
    cover_item_t item;
    int n;
    n = codeword_len(parity_reg);
    for (int i = 0; i < count; i++) begin
      item.mode = (i == n - 1) ? mode : 1'($urandom_range(0, 1));
      item.message = (i == n - 1) ? msg : 8'($urandom_range(0, 255));
      item.cover_byte = (fill < 0) ? 8'($urandom_range(0, 255)) : 8'(fill);
      item.wait_drain = drain && (i == 0);
      cover_queue.push_back(item);
      items_queued++;
    end
  endtask

  task automatic wait_for_idle();
    while (items_taken != items_queued || due_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // A write also drops any partly received codeword.
  task automatic write_parity_bits(input logic [3:0] value);
    cfg_ch.parity_bits <= value;
    cfg_ch.valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    parity_reg = value;
    syn_acc = 8'h00;
    byte_pos = 0;
  endtask

  // Cover byte driver.
  always @(posedge clk) begin
    if (rst) begin
      cover_ch.valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (cover_ch.valid && cover_ch.ready) begin
        absorb_cover_byte(cover_ch.mode, cover_ch.cover_byte, cover_ch.message);
        items_taken++;
      end
      if (!cover_ch.valid || cover_ch.ready) begin
        if (send_gap > 0) begin
          send_gap--;
          cover_ch.valid <= 1'b0;
        end else if (cover_queue.size() != 0 &&
                     !(cover_queue[0].wait_drain && due_results.size() != 0)) begin
          next_item = cover_queue.pop_front();
          cover_ch.valid <= 1'b1;
          cover_ch.mode <= next_item.mode;
          cover_ch.cover_byte <= next_item.cover_byte;
          cover_ch.message <= next_item.message;
          if (!calm && bursts_on && $urandom_range(0, 7) == 0)
            send_gap = $urandom_range(1, 15);
        end else begin
          cover_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor.
  always @(posedge clk) begin
    result_t got, want;
    if (rst) begin
      result_ch.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (result_ch.valid && result_ch.ready) begin
        got.out_byte = result_ch.out_byte;
        got.syndrome = result_ch.syndrome;
        got.last = result_ch.last;
        if (due_results.size() == 0) begin
          errors++;
          if (errors <= REPORT_LIMIT)
            $display("unexpected result: out_byte %02h syndrome %02h last %0b",
                     got.out_byte, got.syndrome, got.last);
        end else begin
          want = due_results.pop_front();
          if (got !== want) begin
            errors++;
            if (errors <= REPORT_LIMIT)
              $display("mismatch: expected out_byte %02h syndrome %02h last %0b, %s",
                       want.out_byte, want.syndrome, want.last,
                       $sformatf("got out_byte %02h syndrome %02h last %0b",
                                 got.out_byte, got.syndrome, got.last));
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= 1'b1;
        if (!calm && bursts_on && $urandom_range(0, 7) == 0)
          stall_left = $urandom_range(1, 15);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    int plan[$];
    int k_pick, n, r, fill, phase_start;
    rst = 1'b1;
    cover_ch.valid = 1'b0;
    cover_ch.mode = MODE_EXTRACT;
    cover_ch.cover_byte = 8'h00;
    cover_ch.message = 8'h00;
    result_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.parity_bits = PARITY_RESET;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part at the reset setting of five parity bits.
    n = codeword_len(parity_reg);
    queue_codeword(MODE_EXTRACT, 8'h00, 255, n, 1'b0);
    queue_codeword(MODE_EMBED, 8'hFF, 0, n, 1'b0);
    queue_codeword(MODE_EMBED, 8'h00, 255, n, 1'b1);
    queue_codeword(MODE_EMBED, 8'($urandom_range(0, 255)), -1, n, 1'b0);
    // This codeword is cut short and then dropped by the next write.
    queue_codeword(MODE_EXTRACT, 8'h00, -1, n / 2, 1'b0);
    wait_for_idle();

    // One byte per codeword; the padding bit alone must not count.
    write_parity_bits(4'd3);
    queue_codeword(MODE_EXTRACT, 8'h00, 8'h01, 1, 1'b0);
    queue_codeword(MODE_EMBED, 8'hFF, 8'hFE, 1, 1'b0);
    queue_codeword(MODE_EMBED, 8'h00, 8'h00, 1, 1'b0);
    wait_for_idle();

    // A setting below the legal range behaves as the smallest one.
    write_parity_bits(4'd0);
    queue_codeword(MODE_EMBED, 8'($urandom_range(0, 255)), -1, 1, 1'b0);
    wait_for_idle();

    plan = '{15, 8, 1, 6, 4, 9, 7, 2, 14, 3, 5, 10};
    while (items_queued < 400) begin
      if (plan.size() != 0) k_pick = plan.pop_front();
      else k_pick = $urandom_range(0, 15);
      write_parity_bits(4'(k_pick));
      calm = (items_queued >= 340);
      bursts_on = !calm && ($urandom_range(0, 3) != 0);
      phase_start = items_queued;
      n = codeword_len(parity_reg);
      while (items_queued - phase_start < 36) begin
        r = $urandom_range(0, 7);
        fill = (r == 0) ? 0 : (r == 1) ? 255 : -1;
        queue_codeword(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)), fill, n,
                       $urandom_range(0, 9) == 0);
      end
      if (n > 1 && $urandom_range(0, 2) == 0)
        queue_codeword(MODE_EMBED, 8'h00, -1, $urandom_range(1, n - 1), 1'b0);
      wait_for_idle();
    end

    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/hme_pkg.sv
rtl/hme_if.sv
rtl/hme_ctrl.sv
rtl/hme_dp.sv
rtl/hamming_matrix_embedding.sv
tb/tb_hamming_matrix_embedding.sv
